// ----- hw/rtl/jst_pkg.sv -----
// ----------------------------------------------------------------------------
// JSON structure tracker package
// Shared constants, codes and types of the structure tracker.
// ----------------------------------------------------------------------------
package jst_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	localparam logic [7:0] CH_OBJ_OPEN = 8'h7B;
	localparam logic [7:0] CH_ARR_OPEN = 8'h5B;
	localparam logic [7:0] CH_OBJ_CLOSE = 8'h7D;
	localparam logic [7:0] CH_ARR_CLOSE = 8'h5D;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COLON = 8'h3A;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_OBJECT = 2'd1,
		KIND_ARRAY  = 2'd2,
		KIND_KEY    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		MODE_WAIT   = 2'd0,
		MODE_PARSE  = 2'd1,
		MODE_STRING = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ROLE_OTHER = 2'd0,
		ROLE_KEY   = 2'd1,
		ROLE_VALUE = 2'd2,
		ROLE_ENTRY = 2'd3
	} role_t;

	typedef enum logic [1:0] {
		SH_HOLD = 2'd0,
		SH_PUSH = 2'd1,
		SH_POP1 = 2'd2,
		SH_POP2 = 2'd3
	} shift_op_t;

	typedef struct packed {
		shift_op_t op;
		kind_t     kind;
	} stack_cmd_t;

	typedef struct packed {
		kind_t k0;
		kind_t k1;
		kind_t k2;
	} stack_view_t;

	typedef struct packed {
		status_t    status;
		logic [4:0] depth;
		kind_t      top_kind;
		logic [7:0] string_byte;
		logic       string_byte_valid;
		logic       string_end;
		role_t      string_role;
	} result_t;

endpackage

// ----- hw/rtl/jst_cell.sv -----
// ----------------------------------------------------------------------------
// Stack cell
// One entry of the shifting kind stack; takes its value from a neighbour or the pushed kind.
// ----------------------------------------------------------------------------
module jst_cell (
	input  logic             clk,
	input  jst_pkg::shift_op_t op,
	input  jst_pkg::kind_t   up,
	input  jst_pkg::kind_t   dn1,
	input  jst_pkg::kind_t   dn2,
	output jst_pkg::kind_t   kind
);

	jst_pkg::kind_t kind_q;

	always_ff @(posedge clk) begin
		unique case (op)
			jst_pkg::SH_PUSH: kind_q <= up;
			jst_pkg::SH_POP1: kind_q <= dn1;
			jst_pkg::SH_POP2: kind_q <= dn2;
			default:          kind_q <= kind_q;
		endcase
	end

	assign kind = kind_q;

endmodule

// ----- hw/rtl/jst_ctrl.sv -----
// ----------------------------------------------------------------------------
// Parser control
// Holds the parse mode and stack count, decodes each byte into a stack
// command and forms the result of the beat.
// ----------------------------------------------------------------------------
module jst_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    fire,
	input  logic [7:0]              ch,
	input  jst_pkg::stack_view_t    view,
	output jst_pkg::stack_cmd_t     cmd,
	output jst_pkg::result_t        res
);

	jst_pkg::mode_t mode_q, mode_d;
	logic [jst_pkg::CNT_W-1:0] count_q, count_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= jst_pkg::MODE_WAIT;
			count_q <= '0;
		end else if (fire) begin
			mode_q <= mode_d;
			count_q <= count_d;
		end
	end

	always_comb begin
		logic is_open, is_close, has_room, ge2, ge3;
		jst_pkg::kind_t top, next_top;
		jst_pkg::shift_op_t op;

		is_open = (ch == jst_pkg::CH_OBJ_OPEN) || (ch == jst_pkg::CH_ARR_OPEN);
		is_close = (ch == jst_pkg::CH_OBJ_CLOSE) || (ch == jst_pkg::CH_ARR_CLOSE);
		has_room = count_q < jst_pkg::CNT_W'(jst_pkg::STACK_DEPTH);
		ge2 = count_q >= jst_pkg::CNT_W'(2);
		ge3 = count_q >= jst_pkg::CNT_W'(3);
		top = (count_q != '0) ? view.k0 : jst_pkg::KIND_NONE;
		next_top = ge2 ? view.k1 : jst_pkg::KIND_NONE;

		op = jst_pkg::SH_HOLD;
		mode_d = mode_q;
		cmd.kind = (ch == jst_pkg::CH_OBJ_OPEN) ? jst_pkg::KIND_OBJECT : jst_pkg::KIND_ARRAY;
		res.status = jst_pkg::ST_OK;
		res.string_byte = '0;
		res.string_byte_valid = 1'b0;
		res.string_end = 1'b0;
		res.string_role = jst_pkg::ROLE_OTHER;

		if (mode_q == jst_pkg::MODE_STRING) begin
			if (ch == jst_pkg::CH_QUOTE) begin
				res.string_end = 1'b1;
				mode_d = jst_pkg::MODE_PARSE;
				unique case (top)
					jst_pkg::KIND_OBJECT: res.string_role = jst_pkg::ROLE_KEY;
					jst_pkg::KIND_ARRAY:  res.string_role = jst_pkg::ROLE_ENTRY;
					jst_pkg::KIND_KEY: begin
						res.string_role = jst_pkg::ROLE_VALUE;
						op = jst_pkg::SH_POP1;
					end
					default: res.string_role = jst_pkg::ROLE_OTHER;
				endcase
			end else begin
				res.string_byte = ch;
				res.string_byte_valid = 1'b1;
			end
		end else if (mode_q == jst_pkg::MODE_WAIT && !is_open) begin
			op = jst_pkg::SH_HOLD;
		end else if (is_open) begin
			if (has_room) begin
				op = jst_pkg::SH_PUSH;
				mode_d = jst_pkg::MODE_PARSE;
			end else begin
				res.status = jst_pkg::ST_FULL;
			end
		end else if (is_close) begin
			if (count_q == '0) begin
				res.status = jst_pkg::ST_EMPTY;
			end else if (next_top == jst_pkg::KIND_KEY) begin
				op = jst_pkg::SH_POP2;
			end else begin
				op = jst_pkg::SH_POP1;
			end
		end else if (ch == jst_pkg::CH_QUOTE) begin
			mode_d = jst_pkg::MODE_STRING;
		end else if (ch == jst_pkg::CH_COLON && top == jst_pkg::KIND_OBJECT) begin
			if (has_room) begin
				op = jst_pkg::SH_PUSH;
				cmd.kind = jst_pkg::KIND_KEY;
			end else begin
				res.status = jst_pkg::ST_FULL;
			end
		end

		unique case (op)
			jst_pkg::SH_PUSH: begin
				count_d = count_q + jst_pkg::CNT_W'(1);
				res.top_kind = cmd.kind;
			end
			jst_pkg::SH_POP1: begin
				count_d = count_q - jst_pkg::CNT_W'(1);
				res.top_kind = next_top;
			end
			jst_pkg::SH_POP2: begin
				count_d = count_q - jst_pkg::CNT_W'(2);
				res.top_kind = ge3 ? view.k2 : jst_pkg::KIND_NONE;
			end
			default: begin
				count_d = count_q;
				res.top_kind = top;
			end
		endcase

		res.depth = 5'(count_d);
		cmd.op = fire ? op : jst_pkg::SH_HOLD;
	end

endmodule

// ----- hw/rtl/jst_out_buf.sv -----
// ----------------------------------------------------------------------------
// Result buffer
// Output register with a skid entry, so that a beat is taken while the
// previous result waits on a stalled receiver.
// ----------------------------------------------------------------------------
module jst_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  jst_pkg::result_t din,
	output logic             full,
	output logic             valid,
	input  logic             stall,
	output jst_pkg::result_t dout
);

	logic main_v_q, skid_v_q;
	jst_pkg::result_t main_q, skid_q;
	logic pop;

	assign pop = main_v_q && !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!main_v_q || pop) begin
				main_v_q <= skid_v_q || push;
				skid_v_q <= skid_v_q && push;
			end else begin
				skid_v_q <= skid_v_q || push;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!main_v_q || pop) begin
			if (skid_v_q) begin
				main_q <= skid_q;
				skid_q <= din;
			end else begin
				main_q <= din;
			end
		end else if (push) begin
			skid_q <= din;
		end
	end

	assign full = skid_v_q;
	assign valid = main_v_q;
	assign dout = main_q;

endmodule

// ----- hw/rtl/json_structure_tracker_top.sv -----
// ----------------------------------------------------------------------------
// JSON structure tracker
// Follows the nesting of a JSON byte stream and passes string content out.
// ----------------------------------------------------------------------------
// The input channel carries one byte of JSON text per beat (ch, byte_valid,
// byte_stall); the output channel carries exactly one result per input beat
// (res_valid, res_stall and the result fields), in order.
// A result is registered in the output buffer when its byte is taken, and the
// block takes one byte every cycle while the receiver keeps up.
// The kind stack is a row of cells that shift as a whole on each push or
// pop, so every byte is settled as it is taken.
// Two results are held at the output: when the receiver stalls, the block
// takes one further byte and then raises byte_stall until a result leaves.
// Reset empties the stack, drops any held results and returns the parser to
// waiting for the first brace or bracket; no clearing pass is needed.
// ----------------------------------------------------------------------------
module json_structure_tracker_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] ch,
	input  logic       byte_valid,
	output logic       byte_stall,
	output logic [1:0] status,
	output logic [4:0] depth,
	output logic [1:0] top_kind,
	output logic [7:0] string_byte,
	output logic       string_byte_valid,
	output logic       string_end,
	output logic [1:0] string_role,
	output logic       res_valid,
	input  logic       res_stall
);

	localparam int D = jst_pkg::STACK_DEPTH;

	logic fire;
	jst_pkg::stack_cmd_t cmd;
	jst_pkg::stack_view_t view;
	jst_pkg::result_t res, res_out;
	jst_pkg::kind_t kind_w [D];
	jst_pkg::kind_t up_w [D];
	jst_pkg::kind_t dn1_w [D];
	jst_pkg::kind_t dn2_w [D];

	assign fire = byte_valid && !byte_stall;

	for (genvar i = 0; i < D; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign up_w[i] = cmd.kind;
		end else begin : g_rest
			assign up_w[i] = kind_w[i-1];
		end
		if (i + 1 < D) begin : g_dn1
			assign dn1_w[i] = kind_w[i+1];
		end else begin : g_dn1_end
			assign dn1_w[i] = jst_pkg::KIND_NONE;
		end
		if (i + 2 < D) begin : g_dn2
			assign dn2_w[i] = kind_w[i+2];
		end else begin : g_dn2_end
			assign dn2_w[i] = jst_pkg::KIND_NONE;
		end
		jst_cell u_cell (
			.clk  (clk),
			.op   (cmd.op),
			.up   (up_w[i]),
			.dn1  (dn1_w[i]),
			.dn2  (dn2_w[i]),
			.kind (kind_w[i])
		);
	end

	assign view.k0 = kind_w[0];
	assign view.k1 = kind_w[1];
	assign view.k2 = dn1_w[1];

	jst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.ch     (ch),
		.view   (view),
		.cmd    (cmd),
		.res    (res)
	);

	jst_out_buf u_out_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fire),
		.din    (res),
		.full   (byte_stall),
		.valid  (res_valid),
		.stall  (res_stall),
		.dout   (res_out)
	);

	assign status = res_out.status;
	assign depth = res_out.depth;
	assign top_kind = res_out.top_kind;
	assign string_byte = res_out.string_byte;
	assign string_byte_valid = res_out.string_byte_valid;
	assign string_end = res_out.string_end;
	assign string_role = res_out.string_role;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> depth <= 5'(D))
		else $error("reported depth exceeds the stack size");

	a_string_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(string_byte_valid && string_end))
		else $error("string content and string end in one beat");

	a_empty_close: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == jst_pkg::ST_EMPTY |->
			depth == 5'd0 && top_kind == jst_pkg::KIND_NONE)
		else $error("empty close reported with a non-empty stack");

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> res_valid)
		else $error("input stalled with no result waiting");

endmodule

// ----- tb/sv/json_structure_tracker_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JSON structure tracker testbench
// Feeds JSON bytes through the tracker with random gaps on the input side and
// random stalls on the result side. A predictor follows the nesting stack and
// the string mode to expect the result of every beat. A short table of
// directed bytes runs first. Random documents, cut-off documents, runs that
// overflow the stack and loose noise follow.
// ----------------------------------------------------------------------------
module json_structure_tracker_top_tb;

	import jst_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_BYTES = 410;

	typedef struct packed {
		logic [7:0] c;
		logic       fixed;
		result_t    want;
	} dir_row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic [7:0] ch;
	logic       byte_valid;
	logic       byte_stall;
	logic [1:0] status;
	logic [4:0] depth;
	logic [1:0] top_kind;
	logic [7:0] string_byte;
	logic       string_byte_valid;
	logic       string_end;
	logic [1:0] string_role;
	logic       res_valid;
	logic       res_stall;

	json_structure_tracker_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.ch(ch),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.status(status),
		.depth(depth),
		.top_kind(top_kind),
		.string_byte(string_byte),
		.string_byte_valid(string_byte_valid),
		.string_end(string_end),
		.string_role(string_role),
		.res_valid(res_valid),
		.res_stall(res_stall)
	);

	// Predicted parser state.
	mode_t      mode_now;
	kind_t      nest[STACK_DEPTH];
	int         nest_cnt;

	result_t    pending[$];
	result_t    want;
	dir_row_t   dir_rows[$];
	logic [7:0] doc_q[$];
	string      lit_chars = "0123456789-+.eEtrufalsn \n";

	bit         no_idle;
	int         rx_left;
	int         fed;
	int         checked;
	int         errors;
	int         cycle_cnt;
	int         n_ends;
	int         n_full;
	int         n_empty;
	int         n_docs;
	int         n_overflow;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic kind_t nest_top();
		if (nest_cnt > 0)
			return nest[nest_cnt - 1];
		return KIND_NONE;
	endfunction

	function automatic result_t track_byte(input logic [7:0] c);
		result_t r;
		r = '0;
		r.status = ST_OK;
		r.string_role = ROLE_OTHER;
		if (mode_now == MODE_STRING) begin
			if (c == CH_QUOTE) begin
				case (nest_top())
					KIND_OBJECT: r.string_role = ROLE_KEY;
					KIND_KEY: begin
						r.string_role = ROLE_VALUE;
						nest_cnt--;
					end
					KIND_ARRAY: r.string_role = ROLE_ENTRY;
					default: r.string_role = ROLE_OTHER;
				endcase
				r.string_end = 1'b1;
				mode_now = MODE_PARSE;
			end else begin
				r.string_byte = c;
				r.string_byte_valid = 1'b1;
			end
		end else if (!(mode_now == MODE_WAIT && c != CH_OBJ_OPEN && c != CH_ARR_OPEN)) begin
			if (c == CH_OBJ_OPEN || c == CH_ARR_OPEN) begin
				if (nest_cnt < STACK_DEPTH) begin
					nest[nest_cnt] = (c == CH_OBJ_OPEN) ? KIND_OBJECT : KIND_ARRAY;
					nest_cnt++;
					mode_now = MODE_PARSE;
				end else begin
					r.status = ST_FULL;
				end
			end else if (c == CH_OBJ_CLOSE || c == CH_ARR_CLOSE) begin
				if (nest_cnt == 0) begin
					r.status = ST_EMPTY;
				end else begin
					nest_cnt--;
					if (nest_top() == KIND_KEY)
						nest_cnt--;
				end
			end else if (c == CH_QUOTE) begin
				mode_now = MODE_STRING;
			end else if (c == CH_COLON && nest_top() == KIND_OBJECT) begin
				if (nest_cnt < STACK_DEPTH) begin
					nest[nest_cnt] = KIND_KEY;
					nest_cnt++;
				end else begin
					r.status = ST_FULL;
				end
			end
		end
		r.depth = nest_cnt[4:0];
		r.top_kind = nest_top();
		return r;
	endfunction

	function automatic result_t res(status_t s, int d, kind_t k, logic [7:0] b, logic bv,
			logic e, role_t ro);
		result_t r;
		r.status = s;
		r.depth = d[4:0];
		r.top_kind = k;
		r.string_byte = b;
		r.string_byte_valid = bv;
		r.string_end = e;
		r.string_role = ro;
		return r;
	endfunction

	function automatic result_t calm(status_t s, int d, kind_t k);
		return res(s, d, k, 8'h00, 1'b0, 1'b0, ROLE_OTHER);
	endfunction

	function automatic dir_row_t row_fixed(logic [7:0] c, result_t w);
		dir_row_t r;
		r.c = c;
		r.fixed = 1'b1;
		r.want = w;
		return r;
	endfunction

	function automatic dir_row_t row_pred(logic [7:0] c);
		dir_row_t r;
		r = '0;
		r.c = c;
		return r;
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 30);
		return $urandom_range(0, 2);
	endfunction

	function automatic logic [7:0] str_char();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b == CH_QUOTE)
			b = 8'h5C;
		return b;
	endfunction

	function automatic logic [7:0] pick_punct();
		case ($urandom_range(0, 6))
			0: return CH_OBJ_OPEN;
			1: return CH_ARR_OPEN;
			2: return CH_OBJ_CLOSE;
			3: return CH_ARR_CLOSE;
			4: return CH_QUOTE;
			5: return CH_COLON;
			default: return 8'h2C;
		endcase
	endfunction

	function automatic void add_str();
		int n;
		n = $urandom_range(0, 6);
		doc_q.push_back(CH_QUOTE);
		repeat (n) doc_q.push_back(str_char());
		doc_q.push_back(CH_QUOTE);
	endfunction

	function automatic void add_scalar();
		int n;
		if ($urandom_range(0, 1)) begin
			add_str();
		end else begin
			n = $urandom_range(1, 5);
			repeat (n) doc_q.push_back(lit_chars[$urandom_range(0, lit_chars.len() - 1)]);
		end
	endfunction

	// Builds one document with balanced nesting and random content into doc_q.
	function automatic void build_doc(input int lvl_max, input int len_max);
		kind_t ctx[$];
		int    cnt[$];
		bit    need_val;
		bit    done;
		int    last;
		doc_q.delete();
		need_val = 1'b1;
		done = 1'b0;
		while (!done) begin
			last = ctx.size() - 1;
			if (need_val) begin
				if (doc_q.size() == 0 || (ctx.size() < lvl_max && doc_q.size() < len_max
						&& $urandom_range(0, 2) != 0)) begin
					if ($urandom_range(0, 1)) begin
						doc_q.push_back(CH_OBJ_OPEN);
						ctx.push_back(KIND_OBJECT);
					end else begin
						doc_q.push_back(CH_ARR_OPEN);
						ctx.push_back(KIND_ARRAY);
					end
					cnt.push_back(0);
				end else begin
					add_scalar();
				end
				need_val = 1'b0;
			end else if (ctx.size() == 0) begin
				done = 1'b1;
			end else if (cnt[last] < 4 && doc_q.size() < len_max && $urandom_range(0, 3) != 0) begin
				if (cnt[last] > 0)
					doc_q.push_back(8'h2C);
				cnt[last] = cnt[last] + 1;
				if (ctx[last] == KIND_OBJECT) begin
					add_str();
					doc_q.push_back(CH_COLON);
				end
				need_val = 1'b1;
			end else begin
				doc_q.push_back(ctx[last] == KIND_OBJECT ? CH_OBJ_CLOSE : CH_ARR_CLOSE);
				ctx.delete(last);
				cnt.delete(last);
			end
		end
	endfunction

	task automatic feed_byte(input logic [7:0] c, input logic fixed, input result_t fixed_res);
		int      gap;
		result_t p;
		gap = no_idle ? 0 : gap_len();
		if (gap > 0) begin
			@(negedge clk);
			byte_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		ch <= c;
		byte_valid <= 1'b1;
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		p = track_byte(c);
		pending.push_back(fixed ? fixed_res : p);
		fed++;
	endtask

	task automatic put(input logic [7:0] c);
		feed_byte(c, 1'b0, '0);
	endtask

	task automatic send_doc(input int n);
		for (int i = 0; i < n; i++)
			put(doc_q[i]);
	endtask

	// Fills the stack, pushes against the full stack and then empties it past the bottom.
	task automatic overflow_run();
		if (mode_now == MODE_STRING)
			put(CH_QUOTE);
		while (nest_cnt < STACK_DEPTH - 1)
			put($urandom_range(0, 1) ? CH_OBJ_OPEN : CH_ARR_OPEN);
		put(CH_OBJ_OPEN);
		put(CH_ARR_OPEN);
		put(CH_COLON);
		put(CH_QUOTE);
		put(8'h78);
		put(CH_QUOTE);
		while (nest_cnt > 0)
			put($urandom_range(0, 1) ? CH_OBJ_CLOSE : CH_ARR_CLOSE);
		put(CH_ARR_CLOSE);
		n_overflow++;
	endtask

	task automatic check_field(input string name, input logic [7:0] e, input logic [7:0] a);
		if (a !== e) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
		end
	endtask

	always @(negedge clk) begin
		if (no_idle) begin
			res_stall <= 1'b0;
		end else if (rx_left > 0) begin
			rx_left--;
		end else if (!res_stall && $urandom_range(0, 2) == 0) begin
			res_stall <= 1'b1;
			rx_left = gap_len();
		end else begin
			res_stall <= 1'b0;
			rx_left = $urandom_range(0, 4);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: result with none expected, got status %0h depth %0h top %0h",
					$time, status, depth, top_kind);
			end else begin
				want = pending.pop_front();
				check_field("status", 8'(want.status), 8'(status));
				check_field("depth", 8'(want.depth), 8'(depth));
				check_field("top_kind", 8'(want.top_kind), 8'(top_kind));
				check_field("string_byte", want.string_byte, string_byte);
				check_field("string_byte_valid", 8'(want.string_byte_valid),
					8'(string_byte_valid));
				check_field("string_end", 8'(want.string_end), 8'(string_end));
				check_field("string_role", 8'(want.string_role), 8'(string_role));
				checked++;
				if (want.string_end)
					n_ends++;
				if (want.status == ST_FULL)
					n_full++;
				if (want.status == ST_EMPTY)
					n_empty++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding",
				cycle_cnt, pending.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int sel;
		int dir_count;
		arst_n = 1'b0;
		ch = 8'h00;
		byte_valid = 1'b0;
		res_stall = 1'b0;
		no_idle = 1'b0;
		rx_left = 0;
		mode_now = MODE_WAIT;
		nest_cnt = 0;
		for (int i = 0; i < STACK_DEPTH; i++)
			nest[i] = KIND_NONE;

		dir_rows.push_back(row_fixed(8'h78, calm(ST_OK, 0, KIND_NONE)));
		dir_rows.push_back(row_fixed(CH_OBJ_CLOSE, calm(ST_OK, 0, KIND_NONE)));
		dir_rows.push_back(row_fixed(CH_QUOTE, calm(ST_OK, 0, KIND_NONE)));
		dir_rows.push_back(row_fixed(8'hFF, calm(ST_OK, 0, KIND_NONE)));
		dir_rows.push_back(row_fixed(CH_OBJ_OPEN, calm(ST_OK, 1, KIND_OBJECT)));
		dir_rows.push_back(row_pred(CH_QUOTE));
		dir_rows.push_back(row_fixed(8'h6B,
			res(ST_OK, 1, KIND_OBJECT, 8'h6B, 1'b1, 1'b0, ROLE_OTHER)));
		dir_rows.push_back(row_fixed(CH_QUOTE,
			res(ST_OK, 1, KIND_OBJECT, 8'h00, 1'b0, 1'b1, ROLE_KEY)));
		dir_rows.push_back(row_fixed(CH_COLON, calm(ST_OK, 2, KIND_KEY)));
		dir_rows.push_back(row_fixed(CH_ARR_OPEN, calm(ST_OK, 3, KIND_ARRAY)));
		dir_rows.push_back(row_pred(CH_QUOTE));
		dir_rows.push_back(row_pred(8'h5C));
		dir_rows.push_back(row_pred(8'h00));
		dir_rows.push_back(row_pred(8'hFF));
		dir_rows.push_back(row_fixed(CH_QUOTE,
			res(ST_OK, 3, KIND_ARRAY, 8'h00, 1'b0, 1'b1, ROLE_ENTRY)));
		dir_rows.push_back(row_fixed(CH_ARR_CLOSE, calm(ST_OK, 1, KIND_OBJECT)));
		dir_rows.push_back(row_pred(CH_COLON));
		dir_rows.push_back(row_pred(CH_QUOTE));
		dir_rows.push_back(row_fixed(CH_QUOTE,
			res(ST_OK, 1, KIND_OBJECT, 8'h00, 1'b0, 1'b1, ROLE_VALUE)));
		dir_rows.push_back(row_fixed(CH_OBJ_CLOSE, calm(ST_OK, 0, KIND_NONE)));
		dir_rows.push_back(row_fixed(CH_OBJ_CLOSE, calm(ST_EMPTY, 0, KIND_NONE)));
		dir_rows.push_back(row_fixed(CH_COLON, calm(ST_OK, 0, KIND_NONE)));
		dir_rows.push_back(row_pred(CH_QUOTE));
		dir_rows.push_back(row_pred(8'h41));
		dir_rows.push_back(row_fixed(CH_QUOTE,
			res(ST_OK, 0, KIND_NONE, 8'h00, 1'b0, 1'b1, ROLE_OTHER)));
		dir_rows.push_back(row_pred(CH_ARR_OPEN));
		dir_rows.push_back(row_pred(CH_COLON));
		dir_rows.push_back(row_pred(CH_ARR_CLOSE));

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			feed_byte(dir_rows[i].c, dir_rows[i].fixed, dir_rows[i].want);
		dir_count = fed;

		while (fed - dir_count < RANDOM_BYTES) begin
			sel = $urandom_range(0, 19);
			no_idle = ($urandom_range(0, 5) == 0);
			if (n_overflow < 2 || sel == 0) begin
				overflow_run();
			end else if (sel <= 16) begin
				if (mode_now == MODE_STRING)
					put(CH_QUOTE);
				build_doc($urandom_range(1, 5), 60);
				if (sel <= 13) begin
					send_doc(doc_q.size());
					n_docs++;
				end else begin
					send_doc($urandom_range(1, doc_q.size()));
					repeat ($urandom_range(0, 2))
						put($urandom_range(0, 1) ? CH_OBJ_CLOSE : CH_ARR_CLOSE);
				end
			end else begin
				repeat ($urandom_range(1, 12))
					put($urandom_range(0, 1) ? pick_punct() : 8'($urandom_range(0, 255)));
			end
		end
		no_idle = 1'b0;
		@(negedge clk);
		byte_valid <= 1'b0;

		while (pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		$display("Fed %0d bytes (%0d directed, %0d complete documents, %0d stack overflow runs).",
			fed, dir_count, n_docs, n_overflow);
		$display("Checked %0d results: %0d string ends, %0d stack-full, %0d empty-close errors.",
			checked, n_ends, n_full, n_empty);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- json_structure_tracker_top.f -----
hw/rtl/jst_pkg.sv
hw/rtl/jst_cell.sv
hw/rtl/jst_ctrl.sv
hw/rtl/jst_out_buf.sv
hw/rtl/json_structure_tracker_top.sv
tb/sv/json_structure_tracker_top_tb.sv
